// ----- hw/rtl/bbs_pkg.sv -----
// Shared types, constants and register codes for the 3x3 box blur stream.
package bbs_pkg;

  // Pixel and coordinate widths
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int COORD_W    = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CHANS_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  // Frame size limits and reset values
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int SIZE_MIN       = 3;
  localparam int SIZE_RST       = 1024;
  localparam int CHANS_RST      = 3;

  // Window and divide-by-nine arithmetic
  localparam int WIN_TAPS    = 9;
  localparam int SUM_W       = 12;
  localparam int DIV9_RECIP  = 7282;
  localparam int RECIP_W     = 13;
  localparam int DIV9_SHIFT  = 16;

  // Output queue
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;
  localparam int FIFO_CW     = 4;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] px_t;
  typedef logic [WIN_TAPS-1:0][CHAN_W-1:0] tap9_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } coord_t;

  typedef struct packed {
    coord_t pos;
    px_t    chan;
  } res_t;

  // Queue status handed from the merge stage to the intake
  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               pop;
  } fifo_stat_t;

endpackage

// ----- hw/rtl/bbs_stream_if.sv -----
// Valid/ready channel interfaces for the pixel input and the blurred result.
interface bbs_in_if;
  import bbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan0_in;
  logic [CHAN_W-1:0] chan1_in;
  logic [CHAN_W-1:0] chan2_in;

  modport source (output valid, output chan0_in, output chan1_in, output chan2_in,
                  input ready);
  modport sink   (input valid, input chan0_in, input chan1_in, input chan2_in,
                  output ready);
endinterface

interface bbs_out_if;
  import bbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [CHAN_W-1:0]  chan0_out;
  logic [CHAN_W-1:0]  chan1_out;
  logic [CHAN_W-1:0]  chan2_out;

  modport source (output valid, output out_row, output out_col, output chan0_out,
                  output chan1_out, output chan2_out, input ready);
  modport sink   (input valid, input out_row, input out_col, input chan0_out,
                  input chan1_out, input chan2_out, output ready);
endinterface

// ----- hw/rtl/box_blur_3x3_stream.sv -----
// Top level of the streaming 3x3 box blur with line stores and channel lanes.
//
// Pixels enter on in_if in raster order, one word per handshake, with up to three
// 8-bit channels side by side. When pixel (y,x) with y>=2 and x>=2 is taken, the
// word for interior pixel (y-1,x-1) follows on out_if: each active channel holds
// the 3x3 neighborhood sum divided by nine, inactive channels hold zero. Border
// pixels produce no word. Pixels in the first two rows or columns produce none.
// Configuration (cfg_we, cfg_idx, cfg_wdata) sets width, height and channel count;
// write it only while no pixel is in flight.
// A taken pixel's result passes the line store read at the accepting edge, then
// the window shift, lane sum, divide and output queue.
// Throughput: one pixel per cycle while in_if.ready is high, set by the single
// read and write port of each line store.
// The result queue holds 8 words; in_if.ready drops only when the queue plus the
// words still in the pipeline would fill it, so the input keeps flowing while
// out_if stalls until that point.
// Reset clears counters, window and queue and restores width 1024, height 1024
// and three channels. Line stores are not cleared.
module box_blur_3x3_stream #(
  parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bbs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  bbs_in_if.sink                           in_if,
  bbs_out_if.source                        out_if
);
  import bbs_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CWW   = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CHW   = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
  localparam int W_RST = (SIZE_RST < MAX_WIDTH) ? SIZE_RST : MAX_WIDTH;
  localparam int H_RST = (SIZE_RST < MAX_HEIGHT) ? SIZE_RST : MAX_HEIGHT;
  localparam int PIPE  = 4;
  localparam int PEND_W = 3;
  localparam int OCC_W = FIFO_CW + 1;

  // Configuration registers
  logic [WW-1:0]      width_r;
  logic [HW-1:0]      height_r;
  logic [CHANS_W-1:0] chans_r;
  logic [CWW-1:0]     wv;
  logic [CHW-1:0]     hv;
  logic [WW-1:0]      w_clamp;
  logic [HW-1:0]      h_clamp;

  // Position counters
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [WW-1:0] x_inc;
  logic [HW-1:0] y_inc;
  logic [XW-1:0] x_dec;
  logic [YW-1:0] y_dec;
  logic          accept;
  logic          emit;

  // Pipeline
  logic                 s1_v_r;
  px_t                  s1_cur_r;
  logic [XW-1:0]        s1_idx_r;
  px_t                  cur;
  logic [PIPE-1:0]      emit_r;
  coord_t               coord_r [PIPE];
  px_t                  up_rd, mid_rd;
  px_t [WIN_TAPS-1:0]   window_r, window_nxt;
  tap9_t                lane_taps [NUM_CHAN];
  px_t                  lane_q;
  logic [NUM_CHAN-1:0]  lane_on;
  logic [CHANS_W-1:0]   chans_eff;
  logic [PEND_W-1:0]    pending;
  logic [OCC_W-1:0]     occupancy;
  fifo_stat_t           fifo_stat;

  // Clamp written frame sizes into the supported range
  always_comb begin
    wv = CWW'(cfg_wdata);
    hv = CHW'(cfg_wdata);
    if (wv < CWW'(SIZE_MIN)) begin
      w_clamp = WW'(SIZE_MIN);
    end else if (wv > CWW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(wv);
    end
    if (hv < CHW'(SIZE_MIN)) begin
      h_clamp = HW'(SIZE_MIN);
    end else if (hv > CHW'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(hv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= HW'(H_RST);
      chans_r  <= CHANS_W'(CHANS_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:   width_r  <= w_clamp;
        REG_IMAGE_HEIGHT:  height_r <= h_clamp;
        REG_CHANNEL_COUNT: chans_r  <= cfg_wdata[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // Enable lanes below the channel count; zero counts as one
  always_comb begin
    chans_eff = (chans_r == '0) ? CHANS_W'(1) : chans_r;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      lane_on[ch] = (ch < int'(chans_eff));
    end
  end

  // Hold off input when the queue could not take every word in flight
  always_comb begin
    pending = '0;
    for (int s = 0; s < PIPE; s++) begin
      pending = PEND_W'(pending + PEND_W'(emit_r[s]));
    end
    occupancy = OCC_W'(fifo_stat.count) + OCC_W'(pending);
  end

  assign in_if.ready = (occupancy < OCC_W'(FIFO_DEPTH));
  assign accept      = in_if.valid & in_if.ready;

  // Advance column and row, wrapping at the frame size
  always_comb begin
    x_inc = WW'(x_r) + WW'(1);
    y_inc = HW'(y_r) + HW'(1);
    x_nxt = x_r;
    y_nxt = y_r;
    if (x_inc >= width_r) begin
      x_nxt = '0;
      y_nxt = (y_inc >= height_r) ? '0 : YW'(y_inc);
    end else begin
      x_nxt = XW'(x_inc);
    end
    emit  = (x_r >= XW'(2)) && (y_r >= YW'(2));
    x_dec = x_r - XW'(1);
    y_dec = y_r - YW'(1);
    cur   = {in_if.chan2_in, in_if.chan1_in, in_if.chan0_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (accept) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // Line stores: read at intake, write back in the following cycle
  bbs_ram #(
    .WIDTH (NUM_CHAN * CHAN_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk     (clk),
    .we      (s1_v_r),
    .waddr   (s1_idx_r),
    .wdata   (mid_rd),
    .re      (accept),
    .raddr   (x_r),
    .rdata_r (up_rd)
  );

  bbs_ram #(
    .WIDTH (NUM_CHAN * CHAN_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk     (clk),
    .we      (s1_v_r),
    .waddr   (s1_idx_r),
    .wdata   (s1_cur_r),
    .re      (accept),
    .raddr   (x_r),
    .rdata_r (mid_rd)
  );

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      emit_r <= '0;
    end else begin
      s1_v_r <= accept;
      emit_r <= {emit_r[PIPE-2:0], accept & emit};
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r <= cur;
      s1_idx_r <= x_r;
    end
    coord_r[0].row <= COORD_W'(y_dec);
    coord_r[0].col <= COORD_W'(x_dec);
    for (int s = 1; s < PIPE; s++) begin
      coord_r[s] <= coord_r[s-1];
    end
  end

  // Shift the window one column and load the new right column
  always_comb begin
    window_nxt = window_r;
    for (int r = 0; r < 3; r++) begin
      window_nxt[3*r]   = window_r[3*r+1];
      window_nxt[3*r+1] = window_r[3*r+2];
    end
    window_nxt[2] = up_rd;
    window_nxt[5] = mid_rd;
    window_nxt[8] = s1_cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_v_r) begin
      window_r <= window_nxt;
    end
  end

  // Per-channel lanes
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      for (int k = 0; k < WIN_TAPS; k++) begin
        lane_taps[ch][k] = window_r[k][ch];
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
    bbs_lane u_lane (
      .clk     (clk),
      .taps    (lane_taps[ch]),
      .lane_on (lane_on[ch]),
      .q_r     (lane_q[ch])
    );
  end

  // Merge lanes with the position and queue the result
  bbs_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (emit_r[PIPE-1]),
    .pos    (coord_r[PIPE-1]),
    .lane_q (lane_q),
    .stat   (fifo_stat),
    .out_if (out_if)
  );

  // The queue never holds more than its depth, counting words still in flight
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= OCC_W'(FIFO_DEPTH))
    else $error("result queue occupancy exceeds depth");

  // A line store write never hits the address read in the same cycle
  a_ram_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && accept) |-> (x_r != s1_idx_r))
    else $error("line store read and write collide");

  // Input is held off only while results are queued
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (fifo_stat.count != '0))
    else $error("input stalled with empty result queue");

  // A popped word always leaves the queue count one lower unless one is pushed
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_stat.pop && !emit_r[PIPE-1]) |=>
      (fifo_stat.count == FIFO_CW'($past(fifo_stat.count) - FIFO_CW'(1))))
    else $error("result queue count lost a pop");

endmodule

// ----- hw/rtl/bbs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module bbs_ram #(
  parameter int WIDTH = bbs_pkg::NUM_CHAN * bbs_pkg::CHAN_W,
  parameter int DEPTH = bbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/bbs_lane.sv -----
// One channel lane: sums the nine window taps and divides the sum by nine.
module bbs_lane (
  input  logic                      clk,
  input  bbs_pkg::tap9_t            taps,
  input  logic                      lane_on,
  output logic [bbs_pkg::CHAN_W-1:0] q_r
);
  import bbs_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [SUM_W-1:0]  row_sum [3];
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic              on_r;
  logic [PROD_W-1:0] prod;
  logic [CHAN_W-1:0] q_nxt;

  // Add each window row, then the three row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SUM_W'(taps[3*r]) + SUM_W'(taps[3*r+1]) + SUM_W'(taps[3*r+2]);
    end
    sum_nxt = row_sum[0] + row_sum[1] + row_sum[2];
  end

  // Divide by nine through the scaled reciprocal; drop inactive channels
  always_comb begin
    prod  = PROD_W'(sum_r) * PROD_W'(DIV9_RECIP);
    q_nxt = on_r ? prod[DIV9_SHIFT +: CHAN_W] : '0;
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    on_r  <= lane_on;
    q_r   <= q_nxt;
  end

endmodule

// ----- hw/rtl/bbs_merge.sv -----
// Merge stage: joins lane results with the pixel position and queues the words.
module bbs_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bbs_pkg::coord_t    pos,
  input  bbs_pkg::px_t       lane_q,
  output bbs_pkg::fifo_stat_t stat,
  bbs_out_if.source          out_if
);
  import bbs_pkg::*;

  res_t                 mem [FIFO_DEPTH];
  res_t                 wr_word;
  res_t                 head;
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                 pop;

  assign wr_word.pos  = pos;
  assign wr_word.chan = lane_q;

  assign pop = out_if.valid & out_if.ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? FIFO_AW'(wr_ptr_r + FIFO_AW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? FIFO_AW'(rd_ptr_r + FIFO_AW'(1)) : rd_ptr_r;
    cnt_nxt    = FIFO_CW'(cnt_r + FIFO_CW'(push) - FIFO_CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the merged word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_word;
    end
  end

  // Present the queue head
  assign head             = mem[rd_ptr_r];
  assign out_if.valid     = (cnt_r != '0);
  assign out_if.out_row   = head.pos.row;
  assign out_if.out_col   = head.pos.col;
  assign out_if.chan0_out = head.chan[0];
  assign out_if.chan1_out = head.chan[1];
  assign out_if.chan2_out = head.chan[2];

  assign stat.count = cnt_r;
  assign stat.pop   = pop;

endmodule

// ----- dv/tb_box_blur_3x3_stream.sv -----
// Self-checking testbench for the streaming 3x3 box blur: raster pixels in, blurred words out.
module tb_box_blur_3x3_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import bbs_pkg::*;

  localparam int unsigned MAX_W       = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H       = MAX_HEIGHT_DEF;
  localparam int unsigned BLUR_DIV    = 9;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned SETTLE_CYC  = 12;
  localparam int unsigned RAND_PIXELS = 800;
  localparam int unsigned WIDE_PART   = 40;
  localparam int unsigned TALL_PART   = 240;
  localparam int unsigned REPORT_MAX  = 10;
  // About 1.2k pixels, slowed by stalls, plus a settle pause per chunk; the limit
  // leaves a wide margin over that run.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    px_t                chan;
  } blur_word_t;

  logic clk;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bbs_in_if  pix_if();
  bbs_out_if blur_if();

  box_blur_3x3_stream u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (pix_if),
    .out_if    (blur_if)
  );

  // Predictor state: configuration copy, line stores, window and counters
  logic [CFG_DATA_W-1:0] img_w_reg;
  logic [CFG_DATA_W-1:0] img_h_reg;
  logic [CHANS_W-1:0]    chans_reg;
  px_t                   upper_line  [MAX_W];
  px_t                   middle_line [MAX_W];
  px_t                   win         [9];
  int unsigned           col_pos;
  int unsigned           row_pos;

  px_t         pixel_q [$];
  blur_word_t  blur_q  [$];
  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic int unsigned sat_size(input logic [CFG_DATA_W-1:0] v,
                                           input int unsigned hi);
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Advance the predictor by one pixel; emit is set when a word is due
  function automatic void blur_pixel(input px_t cur, output bit emit,
                                     output blur_word_t word);
    int unsigned w, h, nch, idx, sum;
    int r, ch, k;
    px_t up, mid;
    w   = sat_size(img_w_reg, MAX_W);
    h   = sat_size(img_h_reg, MAX_H);
    nch = (chans_reg == 0) ? 1 : chans_reg;
    idx = col_pos % MAX_W;
    up  = upper_line[idx];
    mid = middle_line[idx];
    upper_line[idx]  = mid;
    middle_line[idx] = cur;
    // shift the window one column, newest column on the right
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = cur;
    emit = (row_pos >= 2) && (col_pos >= 2);
    word = '0;
    if (emit) begin
      word.row = COORD_W'(row_pos - 1);
      word.col = COORD_W'(col_pos - 1);
      for (ch = 0; ch < NUM_CHAN; ch++) begin
        sum = 0;
        for (k = 0; k < 9; k++) sum += win[k][ch];
        if (ch < nch) word.chan[ch] = CHAN_W'(sum / BLUR_DIV);
      end
    end
    // wrap counters at the configured frame size
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Count the pixels until the counters are back at the frame origin
  function automatic int unsigned pixels_left();
    int unsigned w, h, x, y, n;
    w = sat_size(img_w_reg, MAX_W);
    h = sat_size(img_h_reg, MAX_H);
    x = col_pos;
    y = row_pos;
    n = 0;
    do begin
      n++;
      if (x + 1 >= w) begin
        x = 0;
        y = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        x++;
      end
    end while (x != 0 || y != 0);
    return n;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_IMAGE_WIDTH:   img_w_reg = data;
      REG_IMAGE_HEIGHT:  img_h_reg = data;
      REG_CHANNEL_COUNT: chans_reg = data[CHANS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(input logic [CHAN_W-1:0] c0, input logic [CHAN_W-1:0] c1,
                            input logic [CHAN_W-1:0] c2);
    pixel_q.push_back({c2, c1, c0});
    pixels_queued++;
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) push_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                          CHAN_W'($urandom_range(0, 255)));
  endtask

  // Hold off until every pixel is taken and every word is back, then settle
  task automatic drain();
    while (pixels_taken != pixels_queued || blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Pixel driver: predict on each accepted word, then offer the next one
  always @(posedge clk) begin
    px_t        nxt;
    bit         emit;
    blur_word_t word;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        blur_pixel({pix_if.chan2_in, pix_if.chan1_in, pix_if.chan0_in}, emit, word);
        if (emit) blur_q.push_back(word);
        pixels_taken++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pixel_q.pop_front();
          pix_if.valid    <= 1'b1;
          pix_if.chan0_in <= nxt[0];
          pix_if.chan1_in <= nxt[1];
          pix_if.chan2_in <= nxt[2];
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    blur_word_t got;
    blur_word_t want;
    if (!rst_n) begin
      blur_if.ready <= 1'b0;
    end else begin
      if (blur_if.valid && blur_if.ready) begin
        got.row     = blur_if.out_row;
        got.col     = blur_if.out_col;
        got.chan[0] = blur_if.chan0_out;
        got.chan[1] = blur_if.chan1_out;
        got.chan[2] = blur_if.chan2_out;
        if (blur_q.size() == 0) begin
          if (mismatch_cnt < REPORT_MAX)
            $display("unexpected blur word: row %0d col %0d chan %h %h %h",
                     got.row, got.col, got.chan[0], got.chan[1], got.chan[2]);
          mismatch_cnt++;
        end else begin
          want = blur_q.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.chan[0] !== want.chan[0] || got.chan[1] !== want.chan[1] ||
              got.chan[2] !== want.chan[2]) begin
            if (mismatch_cnt < REPORT_MAX)
              $display({"blur word mismatch: exp row %0d col %0d chan %h %h %h, ",
                        "got row %0d col %0d chan %h %h %h"},
                       want.row, want.col, want.chan[0], want.chan[1], want.chan[2],
                       got.row, got.col, got.chan[0], got.chan[1], got.chan[2]);
            mismatch_cnt++;
          end
        end
      end
      blur_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog on the cycle counter
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned i, left, n, rand_px, cur_w;
    pix_if.valid    = 1'b0;
    pix_if.chan0_in = '0;
    pix_if.chan1_in = '0;
    pix_if.chan2_in = '0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    img_w_reg       = CFG_DATA_W'(SIZE_RST);
    img_h_reg       = CFG_DATA_W'(SIZE_RST);
    chans_reg       = CHANS_W'(CHANS_RST);
    col_pos         = 0;
    row_pos         = 0;
    pixels_queued   = 0;
    pixels_taken    = 0;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    calm            = 1'b0;
    for (i = 0; i < 9; i++) win[i] = '0;
    for (i = 0; i < MAX_W; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame: sizes below the minimum saturate, upper data bits dropped
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    write_reg(REG_CHANNEL_COUNT, 11'h7FF);
    // full-scale neighborhood
    repeat (9) push_pixel(8'hFF, 8'hFF, 8'hFF);
    // alternating bits, zero channel, small ramp that divides exactly
    for (i = 0; i < 9; i++)
      push_pixel((i % 2) ? 8'hAA : 8'h55, 8'h00, CHAN_W'(i + 1));
    drain();
    // channel count zero acts as one
    write_reg(REG_CHANNEL_COUNT, 11'd0);
    for (i = 0; i < 9; i++) push_pixel(8'd200, 8'hFF, CHAN_W'(i * 29));
    drain();

    // Widest frame, width saturated from above, with no idling on either side;
    // shrink mid-row so the column counter wraps past the new width
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    write_reg(REG_CHANNEL_COUNT, 11'd2);
    calm = 1'b1;
    send_random(WIDE_PART);
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'd8);
    send_random(pixels_left());
    drain();

    // Tallest frame, height saturated from above; shrink mid-frame to close it
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd1500);
    write_reg(REG_CHANNEL_COUNT, 11'd1);
    send_random(TALL_PART);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    send_random(pixels_left());
    drain();
    calm = 1'b0;

    // Random frames in chunks; width grows only at the frame origin, height and channel count change at either point
    rand_px = 0;
    while (rand_px < RAND_PIXELS) begin
      if (col_pos == 0 && row_pos == 0) begin
        if ($urandom_range(0, 1))
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                    $urandom_range(15, 64) : $urandom_range(0, 14)));
        if ($urandom_range(0, 1))
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
        if ($urandom_range(0, 1))
          write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 2047)));
      end else if ($urandom_range(0, 3) == 0) begin
        cur_w = sat_size(img_w_reg, MAX_W);
        case ($urandom_range(0, 2))
          0: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, cur_w)));
          1: write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 10)));
          default: write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 2047)));
        endcase
      end
      left = pixels_left();
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, left) : left;
      send_random(n);
      rand_px += n;
      drain();
    end

    if (mismatch_cnt == 0 && blur_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
